/* rtl/rvx_pkg.sv */
`default_nettype none

package rvx_pkg;

   localparam int DATA_WORDS   = 32;
   localparam int DMEM_AW      = $clog2(DATA_WORDS);
   localparam int REG_COUNT    = 32;
   localparam int CLEAR_CYCLES = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
   localparam int CLR_AW       = $clog2(CLEAR_CYCLES);

   localparam logic [31:0] HALT_WORD  = 32'h0000_0063;
   localparam logic [31:0] STORE_BASE = 32'd65536;
   localparam logic [31:0] STORE_SPAN = 32'(DATA_WORDS * 4);
   localparam logic [31:0] SP_RESET   = 32'h0000_0100;
   localparam logic [4:0]  SP_INDEX   = 5'd2;

   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;

   localparam logic [2:0] F3_BEQ  = 3'b000;
   localparam logic [2:0] F3_BNE  = 3'b001;
   localparam logic [2:0] F3_BLT  = 3'b100;
   localparam logic [2:0] F3_BGE  = 3'b101;
   localparam logic [2:0] F3_BLTU = 3'b110;
   localparam logic [2:0] F3_BGEU = 3'b111;

   localparam logic [2:0] F3_ADD  = 3'b000;
   localparam logic [2:0] F3_SLL  = 3'b001;
   localparam logic [2:0] F3_SLT  = 3'b010;
   localparam logic [2:0] F3_SLTU = 3'b011;
   localparam logic [2:0] F3_XOR  = 3'b100;
   localparam logic [2:0] F3_SRL  = 3'b101;
   localparam logic [2:0] F3_OR   = 3'b110;
   localparam logic [2:0] F3_AND  = 3'b111;

   typedef struct packed {
      logic [31:0]        pc_next;
      logic               halt_set;
      logic               halted;
      logic               rd_written;
      logic [4:0]         rd_index;
      logic [31:0]        rd_value;
      logic               is_load;
      logic               mem_written;
      logic [4:0]         mem_index;
      logic [DMEM_AW-1:0] dmem_index;
      logic [31:0]        mem_value;
      logic               fault;
   } exec_result_type;

endpackage

`default_nettype wire

/* rtl/rvx_ram.sv */
`default_nettype none

module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when the same address is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/rvx_exec.sv */
`default_nettype none

module rvx_exec
   import rvx_pkg::*;
(
   input  wire logic [31:0]     instr,
   input  wire logic [31:0]     pc,
   input  wire logic [31:0]     rs1_value,
   input  wire logic [31:0]     rs2_value,
   input  wire logic            halt_flag,
   output exec_result_type      result
);

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;
   logic [31:0] pc_plus4;
   logic [31:0] data_addr;
   logic [31:0] data_off;
   logic        in_range;
   logic        take;
   logic        wr;
   logic [31:0] val;
   logic [31:0] jalr_sum;

   assign opc   = instr[6:0];
   assign rd    = instr[11:7];
   assign f3    = instr[14:12];
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign imm_u = {instr[31:12], 12'b0};

   assign pc_plus4  = pc + 32'd4;
   assign jalr_sum  = rs1_value + imm_i;
   assign data_addr = rs1_value + ((opc == OPC_STORE) ? imm_s : imm_i);
   assign data_off  = data_addr - STORE_BASE;
   assign in_range  = data_off < STORE_SPAN;

   always_comb begin
      case (f3)
         F3_BEQ:  take = rs1_value == rs2_value;
         F3_BNE:  take = rs1_value != rs2_value;
         F3_BLT:  take = $signed(rs1_value) < $signed(rs2_value);
         F3_BGE:  take = $signed(rs1_value) >= $signed(rs2_value);
         F3_BLTU: take = rs1_value < rs2_value;
         F3_BGEU: take = rs1_value >= rs2_value;
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      result            = '0;
      result.pc_next    = pc_plus4;
      result.dmem_index = data_off[2 +: DMEM_AW];
      wr                = 1'b0;
      val               = '0;

      if (halt_flag || instr == HALT_WORD) begin
         // hold the PC on the halt word
         result.pc_next  = pc;
         result.halted   = 1'b1;
         result.halt_set = ~halt_flag;
      end else begin
         case (opc)
            OPC_LUI: begin
               wr  = 1'b1;
               val = imm_u;
            end
            OPC_AUIPC: begin
               wr  = 1'b1;
               val = pc + imm_u;
            end
            OPC_JAL: begin
               wr             = 1'b1;
               val            = pc_plus4;
               result.pc_next = (pc + imm_j) & ~32'd1;
            end
            OPC_JALR: begin
               wr             = 1'b1;
               val            = pc_plus4;
               result.pc_next = jalr_sum & ~32'd1;
            end
            OPC_BRANCH: begin
               if (take) begin
                  result.pc_next = pc + imm_b;
               end
            end
            OPC_LOAD: begin
               if (in_range) begin
                  result.is_load = rd != 5'd0;
                  wr             = 1'b1;
               end else begin
                  result.fault = 1'b1;
               end
            end
            OPC_STORE: begin
               if (in_range) begin
                  result.mem_written = 1'b1;
                  result.mem_index   = data_off[6:2];
                  result.mem_value   = rs2_value;
               end else begin
                  result.fault = 1'b1;
               end
            end
            OPC_OPIMM: begin
               wr  = 1'b1;
               val = (f3 == F3_ADD) ? jalr_sum : {31'b0, rs1_value < imm_i};
            end
            OPC_OP: begin
               wr = 1'b1;
               case (f3)
                  F3_ADD:  val = instr[30] ? rs1_value - rs2_value : rs1_value + rs2_value;
                  F3_SLL:  val = rs1_value << rs2_value[4:0];
                  F3_SLT:  val = {31'b0, $signed(rs1_value) < $signed(rs2_value)};
                  F3_SLTU: val = {31'b0, rs1_value < rs2_value};
                  F3_XOR:  val = rs1_value ^ rs2_value;
                  F3_SRL:  val = rs1_value >> rs2_value[4:0];
                  F3_OR:   val = rs1_value | rs2_value;
                  default: val = rs1_value & rs2_value;
               endcase
            end
            default: begin
            end
         endcase

         if (wr && rd != 5'd0) begin
            result.rd_written = 1'b1;
            result.rd_index   = rd;
            // load data comes from the data store read, registered at the same edge as the result
            result.rd_value   = result.is_load ? 32'd0 : val;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/rv32i_subset_instruction_executor.sv */
`default_nettype none

// Executes one RV32I instruction per item. The req channel carries the word
// fetched at the PC given by the previous result (zero for the first item);
// the rsp channel returns the next PC, the halt flag and any register or
// data store write, plus a fault flag for loads and stores outside the
// window at byte address 65536.
// The register file is read and the word registered into the decode register
// at the accepting edge; execute then fills the result register as the decode
// register advances. A new item is taken every cycle while the receiver does
// not stall; the rate is set by that one execute pass, with results forwarded
// to the next item from the result register.
// After reset the block sweeps the register file and data store, one entry
// of each per cycle until both are cleared, with req_ready low; x2 comes out
// as 256, everything else zero.
// When the receiver stalls the result register holds, the decode register
// fills, and then req_ready drops until rsp_ready returns.
// After the halt word every further item returns the same PC with halted set.
module rv32i_subset_instruction_executor
   import rvx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_pc_next,
   output logic             rsp_halted,
   output logic             rsp_rd_written,
   output logic [4:0]       rsp_rd_index,
   output logic [31:0]      rsp_rd_value,
   output logic             rsp_mem_written,
   output logic [4:0]       rsp_mem_index,
   output logic [31:0]      rsp_mem_value,
   output logic             rsp_fault
);

   logic              clr_busy_ff, clr_busy_in;
   logic [CLR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_rf_en;
   logic              clr_dm_en;

   logic              d_valid_ff, d_valid_in;
   logic [31:0]       d_instr_ff;
   logic              fw_valid_ff, fw_valid_in;
   logic [4:0]        fw_idx_ff;
   logic [31:0]       fw_val_ff;

   logic              e_valid_ff, e_valid_in;
   logic              e_new_ff;
   exec_result_type   e_ff;

   logic [31:0]       pc_ff, pc_in;
   logic              halt_ff, halt_in;

   logic              req_take;
   logic              d_adv;
   logic              item_rf_we;
   logic [31:0]       e_wdata;
   logic [31:0]       dmem_rdata;
   logic [31:0]       rf1_rdata;
   logic [31:0]       rf2_rdata;
   logic [4:0]        rs1_idx;
   logic [4:0]        rs2_idx;
   logic [31:0]       rs1_val;
   logic [31:0]       rs2_val;
   exec_result_type   res;

   logic              rf_we;
   logic [4:0]        rf_waddr;
   logic [31:0]       rf_wdata;
   logic              dm_we;
   logic [DMEM_AW-1:0] dm_waddr;
   logic [31:0]       dm_wdata;

   assign d_adv     = d_valid_ff && (!e_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!d_valid_ff || d_adv);
   assign req_take  = req_valid && req_ready;

   // clearing sweep after reset
   assign clr_rf_en = {1'b0, clr_cnt_ff} < (CLR_AW + 1)'(REG_COUNT);
   assign clr_dm_en = {1'b0, clr_cnt_ff} < (CLR_AW + 1)'(DATA_WORDS);
   assign clr_busy_in = clr_busy_ff && (clr_cnt_ff != CLR_AW'(CLEAR_CYCLES - 1));
   assign clr_cnt_in  = clr_busy_ff ? clr_cnt_ff + CLR_AW'(1) : clr_cnt_ff;

   // result register writes back in its first cycle
   assign e_wdata    = e_ff.is_load ? dmem_rdata : e_ff.rd_value;
   assign item_rf_we = e_valid_ff && e_new_ff && e_ff.rd_written;

   assign rf_we    = clr_busy_ff ? clr_rf_en : item_rf_we;
   assign rf_waddr = clr_busy_ff ? clr_cnt_ff[4:0] : e_ff.rd_index;
   assign rf_wdata = clr_busy_ff ? ((clr_cnt_ff[4:0] == SP_INDEX) ? SP_RESET : 32'd0)
                                 : e_wdata;

   assign dm_we    = clr_busy_ff ? clr_dm_en : (d_adv && res.mem_written);
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff[DMEM_AW-1:0] : res.dmem_index;
   assign dm_wdata = clr_busy_ff ? 32'd0 : res.mem_value;

   rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_rs1 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (req_take),
      .rd_addr (req_instruction_word[19:15]),
      .rd_data (rf1_rdata)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_rs2 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (req_take),
      .rd_addr (req_instruction_word[24:20]),
      .rd_data (rf2_rdata)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (d_adv),
      .rd_addr (res.dmem_index),
      .rd_data (dmem_rdata)
   );

   // forward the older item in the result register first, then the write
   // that landed at the same edge as the register file read
   assign rs1_idx = d_instr_ff[19:15];
   assign rs2_idx = d_instr_ff[24:20];

   always_comb begin
      if (e_valid_ff && e_ff.rd_written && e_ff.rd_index == rs1_idx) begin
         rs1_val = e_wdata;
      end else if (fw_valid_ff && fw_idx_ff == rs1_idx) begin
         rs1_val = fw_val_ff;
      end else begin
         rs1_val = rf1_rdata;
      end
      if (e_valid_ff && e_ff.rd_written && e_ff.rd_index == rs2_idx) begin
         rs2_val = e_wdata;
      end else if (fw_valid_ff && fw_idx_ff == rs2_idx) begin
         rs2_val = fw_val_ff;
      end else begin
         rs2_val = rf2_rdata;
      end
   end

   rvx_exec u_exec (
      .instr     (d_instr_ff),
      .pc        (pc_ff),
      .rs1_value (rs1_val),
      .rs2_value (rs2_val),
      .halt_flag (halt_ff),
      .result    (res)
   );

   always_comb begin
      d_valid_in  = req_take ? 1'b1 : (d_adv ? 1'b0 : d_valid_ff);
      fw_valid_in = req_take ? item_rf_we : fw_valid_ff;
      e_valid_in  = d_adv ? 1'b1 : (rsp_ready ? 1'b0 : e_valid_ff);
      pc_in       = d_adv ? res.pc_next : pc_ff;
      halt_in     = halt_ff || (d_adv && res.halt_set);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         d_valid_ff  <= 1'b0;
         fw_valid_ff <= 1'b0;
         e_valid_ff  <= 1'b0;
         e_new_ff    <= 1'b0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
         d_valid_ff  <= d_valid_in;
         fw_valid_ff <= fw_valid_in;
         e_valid_ff  <= e_valid_in;
         e_new_ff    <= d_adv;
         pc_ff       <= pc_in;
         halt_ff     <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         d_instr_ff <= req_instruction_word;
         fw_idx_ff  <= e_ff.rd_index;
         fw_val_ff  <= e_wdata;
      end
      if (d_adv) begin
         e_ff <= res;
      end
   end

   assign rsp_valid       = e_valid_ff;
   assign rsp_pc_next     = e_ff.pc_next;
   assign rsp_halted      = e_ff.halted;
   assign rsp_rd_written  = e_ff.rd_written;
   assign rsp_rd_index    = e_ff.rd_index;
   assign rsp_rd_value    = e_wdata;
   assign rsp_mem_written = e_ff.mem_written;
   assign rsp_mem_index   = e_ff.mem_index;
   assign rsp_mem_value   = e_ff.mem_value;
   assign rsp_fault       = e_ff.fault;

   a_no_take_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("item accepted during clearing sweep");

   a_halt_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_halted) |-> (!rsp_rd_written && !rsp_mem_written && !rsp_fault))
      else $error("halted result carries a write or fault");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      (rf_we && !clr_busy_ff) |-> (rf_waddr != 5'd0))
      else $error("item wrote register x0");

endmodule

`default_nettype wire
